/* sv/longest_prefix_route_lookup_defines.svh */
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define LPRL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lprl: same-cycle check failed");

// next-cycle implication, checked while out of reset
`define LPRL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lprl: next-cycle check failed");

`endif

/* sv/lprl_pkg.sv */
`timescale 1ns / 1ps

package lprl_pkg;

  localparam int TableDepth = 32;
  localparam int PortCount  = 8;
  localparam int QueueDepth = 2;

  localparam int IdxW   = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CountW = $clog2(TableDepth + 1);
  localparam int QPtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW  = $clog2(QueueDepth + 1);

  localparam int AddrW = 32;
  localparam int LenW  = 6;
  localparam int PortW = 3;
  localparam int TtlW  = 8;
  localparam int MaxLen = 32;

  localparam int InDataW  = 120;
  localparam int OutDataW = 48;
  localparam int StatusW  = 3;

  typedef enum logic [StatusW-1:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_FORWARD  = 3'd2,
    ST_TTL_DROP = 3'd3,
    ST_NO_ROUTE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_TTL_DROP,
    CMD_LOOKUP
  } cmd_kind_e;

  // request payload, lowest field in the lowest bits
  typedef struct packed {
    logic [5:0]       pad;
    logic [TtlW-1:0]  ttl_in;
    logic [AddrW-1:0] dest_address;
    logic [AddrW-1:0] hop_address;
    logic             hop_present;
    logic [PortW-1:0] route_port;
    logic [LenW-1:0]  route_length;
    logic [AddrW-1:0] net_prefix;
  } in_data_t;

  typedef struct packed {
    logic [4:0]       pad;
    logic [TtlW-1:0]  ttl_out;
    logic [AddrW-1:0] link_address;
    logic [PortW-1:0] out_port;
  } out_data_t;

  // classified request between front and back
  typedef struct packed {
    cmd_kind_e        kind;
    logic [AddrW-1:0] addr;     // route prefix or destination
    logic [LenW-1:0]  len;
    logic [PortW-1:0] port;
    logic             hop_flag;
    logic [AddrW-1:0] hop;
    logic [TtlW-1:0]  ttl;      // already decremented for lookups
  } cmd_t;

  typedef struct packed {
    logic [AddrW-1:0] prefix;
    logic [LenW-1:0]  len;
    logic [PortW-1:0] port;
    logic             hop_flag;
    logic [AddrW-1:0] hop;
  } entry_t;

  // len is at most 32 here; a length of 32 gives a mask of all ones
  function automatic logic [AddrW-1:0] len_mask(input logic [LenW-1:0] len);
    len_mask = ~({AddrW{1'b1}} >> len);
  endfunction

endpackage

/* sv/lprl_front.sv */
`timescale 1ns / 1ps

module lprl_front (
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [lprl_pkg::InDataW-1:0]     s_axis_tdata_i,
  input  logic                             s_axis_tuser_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output lprl_pkg::cmd_t                   q_cmd_o
);

  lprl_pkg::in_data_t in_data;
  logic [lprl_pkg::LenW-1:0]  len_c;
  logic [lprl_pkg::PortW-1:0] port_c;

  assign in_data         = lprl_pkg::in_data_t'(s_axis_tdata_i);
  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    len_c = in_data.route_length;
    if (len_c > lprl_pkg::LenW'(lprl_pkg::MaxLen)) begin
      len_c = lprl_pkg::LenW'(lprl_pkg::MaxLen);
    end
    port_c = in_data.route_port;
    if (32'(port_c) >= 32'(lprl_pkg::PortCount)) begin
      port_c = lprl_pkg::PortW'(lprl_pkg::PortCount - 1);
    end
  end

  always_comb begin
    q_cmd_o          = '0;
    q_cmd_o.len      = len_c;
    q_cmd_o.port     = port_c;
    q_cmd_o.hop_flag = in_data.hop_present;
    q_cmd_o.hop      = in_data.hop_present ? in_data.hop_address : '0;
    if (!s_axis_tuser_i) begin
      q_cmd_o.kind = lprl_pkg::CMD_ADD;
      q_cmd_o.addr = in_data.net_prefix;
    end else begin
      q_cmd_o.addr = in_data.dest_address;
      q_cmd_o.ttl  = in_data.ttl_in - lprl_pkg::TtlW'(1);
      // ttl of zero or one would expire here
      if (in_data.ttl_in <= lprl_pkg::TtlW'(1)) begin
        q_cmd_o.kind = lprl_pkg::CMD_TTL_DROP;
      end else begin
        q_cmd_o.kind = lprl_pkg::CMD_LOOKUP;
      end
    end
  end

endmodule

/* sv/lprl_queue.sv */
`timescale 1ns / 1ps

module lprl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lprl_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output lprl_pkg::cmd_t cmd_o,
  input  logic           pop_i
);

  lprl_pkg::cmd_t                 slot_q [lprl_pkg::QueueDepth];
  logic [lprl_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [lprl_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [lprl_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == lprl_pkg::QCntW'(lprl_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == lprl_pkg::QueueDepth - 1) ? '0
               : wr_ptr_q + lprl_pkg::QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == lprl_pkg::QueueDepth - 1) ? '0
               : rd_ptr_q + lprl_pkg::QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + lprl_pkg::QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - lprl_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* sv/lprl_back.sv */
`timescale 1ns / 1ps

module lprl_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  lprl_pkg::cmd_t                    q_cmd_i,
  output logic                              q_pop_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [lprl_pkg::OutDataW-1:0]     m_axis_tdata_o,
  output logic [lprl_pkg::StatusW-1:0]      m_axis_tuser_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                          state_q, state_d;
  logic [lprl_pkg::CountW-1:0]     count_q, count_d;
  logic [lprl_pkg::CountW-1:0]     iss_q, iss_d;
  logic                            pend_q, pend_d;
  logic [lprl_pkg::AddrW-1:0]      dest_q, dest_d;
  logic [lprl_pkg::TtlW-1:0]       ttl_q, ttl_d;
  logic                            found_q, found_d;
  logic [lprl_pkg::LenW-1:0]       best_len_q, best_len_d;
  logic [lprl_pkg::PortW-1:0]      best_port_q, best_port_d;
  logic [lprl_pkg::AddrW-1:0]      best_link_q, best_link_d;
  logic                            out_valid_q, out_valid_d;
  lprl_pkg::status_e               out_status_q, out_status_d;
  lprl_pkg::out_data_t             out_data_q, out_data_d;

  lprl_pkg::entry_t                table_mem [lprl_pkg::TableDepth];
  lprl_pkg::entry_t                rd_entry_q;
  lprl_pkg::entry_t                wr_entry;
  logic                            mem_we, mem_re;
  logic                            out_free, hit;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign mem_re   = (state_q == S_SCAN) && (iss_q < count_q);
  assign hit      = ((((dest_q ^ rd_entry_q.prefix) & lprl_pkg::len_mask(rd_entry_q.len))
                      == '0)) && (!found_q || (rd_entry_q.len >= best_len_q));

  assign wr_entry.prefix   = q_cmd_i.addr;
  assign wr_entry.len      = q_cmd_i.len;
  assign wr_entry.port     = q_cmd_i.port;
  assign wr_entry.hop_flag = q_cmd_i.hop_flag;
  assign wr_entry.hop      = q_cmd_i.hop;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    iss_d        = iss_q;
    pend_d       = 1'b0;
    dest_d       = dest_q;
    ttl_d        = ttl_q;
    found_d      = found_q;
    best_len_d   = best_len_q;
    best_port_d  = best_port_q;
    best_link_d  = best_link_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    q_pop_o      = 1'b0;
    mem_we       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.kind)
            lprl_pkg::CMD_ADD: begin
              out_valid_d = 1'b1;
              out_data_d  = '0;
              if (count_q < lprl_pkg::CountW'(lprl_pkg::TableDepth)) begin
                mem_we       = 1'b1;
                count_d      = count_q + lprl_pkg::CountW'(1);
                out_status_d = lprl_pkg::ST_ADDED;
              end else begin
                out_status_d = lprl_pkg::ST_FULL;
              end
            end
            lprl_pkg::CMD_LOOKUP: begin
              dest_d  = q_cmd_i.addr;
              ttl_d   = q_cmd_i.ttl;
              found_d = 1'b0;
              iss_d   = '0;
              state_d = S_SCAN;
            end
            default: begin
              out_valid_d  = 1'b1;
              out_data_d   = '0;
              out_status_d = lprl_pkg::ST_TTL_DROP;
            end
          endcase
        end
      end
      S_SCAN: begin
        // one table read per cycle, compared from the registered read entry
        if (mem_re) begin
          iss_d  = iss_q + lprl_pkg::CountW'(1);
          pend_d = 1'b1;
        end
        if (pend_q && hit) begin
          found_d     = 1'b1;
          best_len_d  = rd_entry_q.len;
          best_port_d = rd_entry_q.port;
          best_link_d = rd_entry_q.hop_flag ? rd_entry_q.hop : dest_q;
        end
        if (!mem_re && !pend_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          if (found_q) begin
            out_status_d            = lprl_pkg::ST_FORWARD;
            out_data_d.out_port     = best_port_q;
            out_data_d.link_address = best_link_q;
            out_data_d.ttl_out      = ttl_q;
          end else begin
            out_status_d = lprl_pkg::ST_NO_ROUTE;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      iss_q        <= '0;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= lprl_pkg::ST_ADDED;
      out_data_q   <= '0;
      dest_q       <= '0;
      ttl_q        <= '0;
      best_len_q   <= '0;
      best_port_q  <= '0;
      best_link_q  <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      iss_q        <= iss_d;
      pend_q       <= pend_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_data_q   <= out_data_d;
      dest_q       <= dest_d;
      ttl_q        <= ttl_d;
      best_len_q   <= best_len_d;
      best_port_q  <= best_port_d;
      best_link_q  <= best_link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[count_q[lprl_pkg::IdxW-1:0]] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_entry_q <= table_mem[iss_q[lprl_pkg::IdxW-1:0]];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule

/* sv/longest_prefix_route_lookup.sv */
`timescale 1ns / 1ps

// IPv4 longest-prefix route lookup. Each request either adds a route to a
// 32-entry table (status 0, or 1 when the table is full) or routes one
// datagram header: ttl 0 or 1 drops (status 3), otherwise every stored route
// is checked and the longest match wins, the later route on equal lengths
// (status 2 with port, next hop or destination, and ttl - 1; status 4 when
// nothing matches). Exactly one result per request, in request order. A
// lookup scans the route table through its single read port, one entry
// per cycle. A two-entry queue behind the input keeps taking requests,
// until it is full, while a lookup runs or a result waits downstream.
module longest_prefix_route_lookup (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // prefix[31:0], route_length[37:32], route_port[40:38], hop_present[41],
  // hop_address[73:42], dest_address[105:74], ttl_in[113:106], zero pad
  input  logic [lprl_pkg::InDataW-1:0]      s_axis_tdata_i,
  // mode
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // out_port[2:0], link_address[34:3], ttl_out[42:35], zero pad
  output logic [lprl_pkg::OutDataW-1:0]     m_axis_tdata_o,
  // status
  output logic [lprl_pkg::StatusW-1:0]      m_axis_tuser_o
);

  logic           q_full, q_push, q_valid, q_pop;
  lprl_pkg::cmd_t push_cmd, head_cmd;

  lprl_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (push_cmd)
  );

  lprl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .cmd_o      (head_cmd),
    .pop_i      (q_pop)
  );

  lprl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_cmd_i         (head_cmd),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

/* sv/lprl_checker.sv */
`timescale 1ns / 1ps
`include "longest_prefix_route_lookup_defines.svh"

module lprl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [lprl_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [lprl_pkg::StatusW-1:0]  m_axis_tuser_o
);

  logic fwd, out_stall;
  lprl_pkg::out_data_t od;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign fwd       = m_axis_tvalid_o && (m_axis_tuser_o == lprl_pkg::ST_FORWARD);
  assign od        = lprl_pkg::out_data_t'(m_axis_tdata_o);

  // a stalled result holds
  `LPRL_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
  // only forwarded results carry a payload
  `LPRL_ASSERT_NOW(a_drop_zero, m_axis_tvalid_o && !fwd, m_axis_tdata_o == '0)
  // a forwarded datagram had ttl of at least two
  `LPRL_ASSERT_NOW(a_fwd_ttl, fwd, od.ttl_out != '0)
  // status is always one of the defined codes
  `LPRL_ASSERT_NOW(a_status_range, m_axis_tvalid_o, m_axis_tuser_o <= lprl_pkg::StatusW'(lprl_pkg::ST_NO_ROUTE))

endmodule

bind longest_prefix_route_lookup lprl_checker u_lprl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
